// ===== hdl/qsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// qsfe_pkg: shared types and tables for the quadrilateral shape function unit
// Node term tables, fixed-point formats and rounding/saturation helpers.
// ----------------------------------------------------------------------------
package qsfe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;              // coordinate width
    localparam int OUT_W     = 20;              // result field width
    localparam int NODE_W    = 4;
    localparam int OPW       = 21;              // second-level multiplier operand width
    localparam int PW        = 44;              // internal product width
    localparam int SLOTS     = 9;
    localparam int ONE_VAL   = 1 << FRAC_BITS;
    localparam int HALF_VAL  = ONE_VAL >> 1;
    localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN   = -(1 << (OUT_W - 1));

    typedef enum logic [1:0] {
        KIND_Q4,
        KIND_Q8,
        KIND_Q9,
        KIND_NONE
    } kind_t;

    typedef enum logic [1:0] {
        FLD_N,
        FLD_DR,
        FLD_DS
    } fld_t;

    typedef enum logic [1:0] {
        SH_FM1,
        SH_F,
        SH_FP1,
        SH_FP2
    } sh_t;

    typedef enum logic [4:0] {
        SRC_R, SRC_S, SRC_RP, SRC_RM, SRC_SP, SRC_SM, SRC_R2, SRC_S2,
        SRC_RRP, SRC_RRM, SRC_SSP, SRC_SSM, SRC_RHP, SRC_RHM, SRC_SHP, SRC_SHM,
        SRC_ONE
    } src_t;

    typedef struct packed {
        src_t x;
        src_t y;
        sh_t  sh;
        logic neg;
    } term_t;

    function automatic term_t mk(src_t x, src_t y, sh_t sh, logic neg);
        term_t t;
        t.x   = x;
        t.y   = y;
        t.sh  = sh;
        t.neg = neg;
        return t;
    endfunction

    function automatic int unsigned sh_amt(sh_t sh);
        int unsigned a;
        case (sh)
            SH_FM1:  a = FRAC_BITS - 1;
            SH_F:    a = FRAC_BITS;
            SH_FP1:  a = FRAC_BITS + 1;
            default: a = FRAC_BITS + 2;
        endcase
        return a;
    endfunction

    // magnitude rounding, ties away from zero
    function automatic logic signed [PW-1:0] rnd_shift(logic signed [PW-1:0] p,
                                                       int unsigned sh);
        logic [PW-1:0] mag;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        mag = (mag + (PW'(1) << (sh - 1))) >> sh;
        return p[PW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat(logic signed [PW-1:0] v);
        logic signed [OUT_W-1:0] o;
        if (v > PW'(OUT_MAX))
            o = OUT_W'(OUT_MAX);
        else if (v < PW'(OUT_MIN))
            o = OUT_W'(OUT_MIN);
        else
            o = OUT_W'(v);
        return o;
    endfunction

    function automatic logic [NODE_W-1:0] last_idx(kind_t k);
        logic [NODE_W-1:0] n;
        case (k)
            KIND_Q4: n = NODE_W'(3);
            KIND_Q8: n = NODE_W'(7);
            default: n = NODE_W'(8);
        endcase
        return n;
    endfunction

    // midside neighbors of each eight-node corner
    function automatic logic [NODE_W-1:0] adj_a(logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] a;
        case (node)
            4'd2:    a = 4'd5;
            4'd3:    a = 4'd6;
            default: a = 4'd4;
        endcase
        return a;
    endfunction

    function automatic logic [NODE_W-1:0] adj_b(logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] b;
        case (node)
            4'd1:    b = 4'd5;
            4'd2:    b = 4'd6;
            default: b = 4'd7;
        endcase
        return b;
    endfunction

    function automatic term_t term_sel(kind_t k, logic [NODE_W-1:0] node, fld_t f);
        term_t t;
        t = mk(SRC_ONE, SRC_ONE, SH_F, 1'b0);
        if (k != KIND_Q9) begin
            case (f)
                FLD_N: begin
                    case (node)
                        4'd0:    t = mk(SRC_RP, SRC_SP, SH_FP2, 1'b0);
                        4'd1:    t = mk(SRC_RM, SRC_SP, SH_FP2, 1'b0);
                        4'd2:    t = mk(SRC_RM, SRC_SM, SH_FP2, 1'b0);
                        4'd3:    t = mk(SRC_RP, SRC_SM, SH_FP2, 1'b0);
                        4'd4:    t = mk(SRC_R2, SRC_SP, SH_FP1, 1'b0);
                        4'd5:    t = mk(SRC_RM, SRC_S2, SH_FP1, 1'b0);
                        4'd6:    t = mk(SRC_R2, SRC_SM, SH_FP1, 1'b0);
                        default: t = mk(SRC_RP, SRC_S2, SH_FP1, 1'b0);
                    endcase
                end
                FLD_DR: begin
                    case (node)
                        4'd0:    t = mk(SRC_SP, SRC_ONE, SH_FP2, 1'b0);
                        4'd1:    t = mk(SRC_SP, SRC_ONE, SH_FP2, 1'b1);
                        4'd2:    t = mk(SRC_SM, SRC_ONE, SH_FP2, 1'b1);
                        4'd3:    t = mk(SRC_SM, SRC_ONE, SH_FP2, 1'b0);
                        4'd4:    t = mk(SRC_R, SRC_SP, SH_F, 1'b1);
                        4'd5:    t = mk(SRC_S2, SRC_ONE, SH_FP1, 1'b1);
                        4'd6:    t = mk(SRC_R, SRC_SM, SH_F, 1'b1);
                        default: t = mk(SRC_S2, SRC_ONE, SH_FP1, 1'b0);
                    endcase
                end
                default: begin
                    case (node)
                        4'd0:    t = mk(SRC_RP, SRC_ONE, SH_FP2, 1'b0);
                        4'd1:    t = mk(SRC_RM, SRC_ONE, SH_FP2, 1'b0);
                        4'd2:    t = mk(SRC_RM, SRC_ONE, SH_FP2, 1'b1);
                        4'd3:    t = mk(SRC_RP, SRC_ONE, SH_FP2, 1'b1);
                        4'd4:    t = mk(SRC_R2, SRC_ONE, SH_FP1, 1'b0);
                        4'd5:    t = mk(SRC_RM, SRC_S, SH_F, 1'b1);
                        4'd6:    t = mk(SRC_R2, SRC_ONE, SH_FP1, 1'b1);
                        default: t = mk(SRC_RP, SRC_S, SH_F, 1'b1);
                    endcase
                end
            endcase
        end else begin
            case (f)
                FLD_N: begin
                    case (node)
                        4'd0:    t = mk(SRC_RRP, SRC_SSP, SH_FP2, 1'b0);
                        4'd1:    t = mk(SRC_RRM, SRC_SSP, SH_FP2, 1'b1);
                        4'd2:    t = mk(SRC_RRM, SRC_SSM, SH_FP2, 1'b0);
                        4'd3:    t = mk(SRC_RRP, SRC_SSM, SH_FP2, 1'b1);
                        4'd4:    t = mk(SRC_SSP, SRC_R2, SH_FP1, 1'b0);
                        4'd5:    t = mk(SRC_RRM, SRC_S2, SH_FP1, 1'b1);
                        4'd6:    t = mk(SRC_SSM, SRC_R2, SH_FP1, 1'b1);
                        4'd7:    t = mk(SRC_RRP, SRC_S2, SH_FP1, 1'b0);
                        default: t = mk(SRC_R2, SRC_S2, SH_F, 1'b0);
                    endcase
                end
                FLD_DR: begin
                    case (node)
                        4'd0:    t = mk(SRC_RHP, SRC_SSP, SH_FP1, 1'b0);
                        4'd1:    t = mk(SRC_RHM, SRC_SSP, SH_FP1, 1'b0);
                        4'd2:    t = mk(SRC_RHM, SRC_SSM, SH_FP1, 1'b1);
                        4'd3:    t = mk(SRC_RHP, SRC_SSM, SH_FP1, 1'b1);
                        4'd4:    t = mk(SRC_R, SRC_SSP, SH_F, 1'b1);
                        4'd5:    t = mk(SRC_RHM, SRC_S2, SH_F, 1'b0);
                        4'd6:    t = mk(SRC_R, SRC_SSM, SH_F, 1'b0);
                        4'd7:    t = mk(SRC_RHP, SRC_S2, SH_F, 1'b0);
                        default: t = mk(SRC_R, SRC_S2, SH_FM1, 1'b1);
                    endcase
                end
                default: begin
                    case (node)
                        4'd0:    t = mk(SRC_SHP, SRC_RRP, SH_FP1, 1'b0);
                        4'd1:    t = mk(SRC_SHP, SRC_RRM, SH_FP1, 1'b1);
                        4'd2:    t = mk(SRC_SHM, SRC_RRM, SH_FP1, 1'b1);
                        4'd3:    t = mk(SRC_SHM, SRC_RRP, SH_FP1, 1'b0);
                        4'd4:    t = mk(SRC_SHP, SRC_R2, SH_F, 1'b0);
                        4'd5:    t = mk(SRC_S, SRC_RRM, SH_F, 1'b0);
                        4'd6:    t = mk(SRC_SHM, SRC_R2, SH_F, 1'b0);
                        4'd7:    t = mk(SRC_S, SRC_RRP, SH_F, 1'b1);
                        default: t = mk(SRC_S, SRC_R2, SH_FM1, 1'b1);
                    endcase
                end
            endcase
        end
        return t;
    endfunction

endpackage

// ===== hdl/quad_shape_function_eval.sv =====
// Path: an accepted input is held in stage 0; each node result then passes the stage 1 to
// stage 4 registers and is presented until m_tready is high.
// Throughput: one node result per cycle unless the output stalls; an item yields 4, 8 or 9
// node results (four-node, eight-node, nine-node) from the one-node-per-cycle sequencer.
// Unknown element kinds are taken and produce no result.
// Reset (aresetn low, synchronous) empties the pipeline and sets the derivative enable to 1.
// ----------------------------------------------------------------------------
// quad_shape_function_eval: Q4/Q8/Q9 quadrilateral shape functions
// Walks the nodes of one element and streams N, dN/dr, dN/ds per node
// through a four-stage multiply pipeline.
// ----------------------------------------------------------------------------
module quad_shape_function_eval (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // derivatives_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // coord_r[17:0], coord_s[35:18], zero pad
    input  logic [1:0]  s_tuser,       // element_kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // node_number[3:0], shape_value[23:4],
                                       // slope_r[43:24], slope_s[63:44]
    output logic        m_tlast        // last_node
);
    import qsfe_pkg::*;

    typedef struct packed {
        logic signed [OPW-1:0] r, s, rp, rm, sp, sm, r2, s2;
        logic signed [OPW-1:0] rrp, rrm, ssp, ssm, rhp, rhm, shp, shm;
    } base_t;

    function automatic logic signed [OPW-1:0] pick(src_t sel, base_t b);
        logic signed [OPW-1:0] v;
        case (sel)
            SRC_R:   v = b.r;
            SRC_S:   v = b.s;
            SRC_RP:  v = b.rp;
            SRC_RM:  v = b.rm;
            SRC_SP:  v = b.sp;
            SRC_SM:  v = b.sm;
            SRC_R2:  v = b.r2;
            SRC_S2:  v = b.s2;
            SRC_RRP: v = b.rrp;
            SRC_RRM: v = b.rrm;
            SRC_SSP: v = b.ssp;
            SRC_SSM: v = b.ssm;
            SRC_RHP: v = b.rhp;
            SRC_RHM: v = b.rhm;
            SRC_SHP: v = b.shp;
            SRC_SHM: v = b.shm;
            default: v = OPW'(ONE_VAL);
        endcase
        return v;
    endfunction

    // configuration
    logic de_reg;

    // stage 0: item hold and node sequencer
    logic                     hold_valid_reg;
    logic signed [IN_W-1:0]   r0_reg, s0_reg;
    kind_t                    kind0_reg;
    logic [NODE_W-1:0]        node0_reg;

    // stage 1: first-level products
    logic                     v1_reg, last1_reg;
    kind_t                    kind1_reg;
    logic [NODE_W-1:0]        node1_reg;
    logic signed [IN_W-1:0]   r1_reg, s1_reg;
    logic signed [2*IN_W-1:0] rr1_reg, ss1_reg;
    logic signed [2*IN_W:0]   rrp1_reg, rrm1_reg, ssp1_reg, ssm1_reg;

    // stage 2: selected operands
    logic                     v2_reg, last2_reg, corr2_reg;
    logic [NODE_W-1:0]        node2_reg;
    logic signed [OPW-1:0]    x2_reg [SLOTS];
    logic signed [OPW-1:0]    y2_reg [SLOTS];
    sh_t                      sh2_reg [SLOTS];
    logic [SLOTS-1:0]         neg2_reg;

    // stage 3: second-level products
    logic                     v3_reg, last3_reg, corr3_reg;
    logic [NODE_W-1:0]        node3_reg;
    logic signed [PW-1:0]     p3_reg [SLOTS];
    sh_t                      sh3_reg [SLOTS];
    logic [SLOTS-1:0]         neg3_reg;

    // stage 4: output register
    logic                     v4_reg, last4_reg;
    logic [NODE_W-1:0]        node4_reg;
    logic signed [OUT_W-1:0]  n4_reg, dr4_reg, ds4_reg;

    logic en1, en2, en3, en4, issue, is_last0, accept;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign issue    = hold_valid_reg && en1;
    assign is_last0 = (node0_reg == last_idx(kind0_reg));
    assign s_tready = !hold_valid_reg || (issue && is_last0);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            de_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            de_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            // drop unknown kinds here
            hold_valid_reg <= (kind_t'(s_tuser) != KIND_NONE);
        end else if (issue && is_last0) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            r0_reg    <= s_tdata[17:0];
            s0_reg    <= s_tdata[35:18];
            kind0_reg <= kind_t'(s_tuser);
            node0_reg <= '0;
        end else if (issue) begin
            node0_reg <= node0_reg + NODE_W'(1);
        end
    end

    // stage 1
    logic signed [IN_W:0] rp0, rm0, sp0, sm0;
    always_comb begin
        rp0 = (IN_W+1)'(ONE_VAL) + (IN_W+1)'(r0_reg);
        rm0 = (IN_W+1)'(ONE_VAL) - (IN_W+1)'(r0_reg);
        sp0 = (IN_W+1)'(ONE_VAL) + (IN_W+1)'(s0_reg);
        sm0 = (IN_W+1)'(ONE_VAL) - (IN_W+1)'(s0_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            last1_reg <= is_last0;
            kind1_reg <= kind0_reg;
            node1_reg <= node0_reg;
            r1_reg    <= r0_reg;
            s1_reg    <= s0_reg;
            rr1_reg   <= r0_reg * r0_reg;
            ss1_reg   <= s0_reg * s0_reg;
            rrp1_reg  <= r0_reg * rp0;
            rrm1_reg  <= r0_reg * rm0;
            ssp1_reg  <= s0_reg * sp0;
            ssm1_reg  <= s0_reg * sm0;
        end
    end

    // stage 2: base values and operand selection
    base_t                 b1;
    logic signed [OPW-1:0] x2_next [SLOTS];
    logic signed [OPW-1:0] y2_next [SLOTS];
    sh_t                   sh2_next [SLOTS];
    logic [SLOTS-1:0]      neg2_next;
    term_t                 tsel [SLOTS];

    always_comb begin
        b1.r   = OPW'(r1_reg);
        b1.s   = OPW'(s1_reg);
        b1.rp  = OPW'(ONE_VAL) + OPW'(r1_reg);
        b1.rm  = OPW'(ONE_VAL) - OPW'(r1_reg);
        b1.sp  = OPW'(ONE_VAL) + OPW'(s1_reg);
        b1.sm  = OPW'(ONE_VAL) - OPW'(s1_reg);
        b1.r2  = OPW'(ONE_VAL) - OPW'(rnd_shift(PW'(rr1_reg), FRAC_BITS));
        b1.s2  = OPW'(ONE_VAL) - OPW'(rnd_shift(PW'(ss1_reg), FRAC_BITS));
        b1.rrp = OPW'(rnd_shift(PW'(rrp1_reg), FRAC_BITS));
        b1.rrm = OPW'(rnd_shift(PW'(rrm1_reg), FRAC_BITS));
        b1.ssp = OPW'(rnd_shift(PW'(ssp1_reg), FRAC_BITS));
        b1.ssm = OPW'(rnd_shift(PW'(ssm1_reg), FRAC_BITS));
        b1.rhp = OPW'(r1_reg) + OPW'(HALF_VAL);
        b1.rhm = OPW'(r1_reg) - OPW'(HALF_VAL);
        b1.shp = OPW'(s1_reg) + OPW'(HALF_VAL);
        b1.shm = OPW'(s1_reg) - OPW'(HALF_VAL);

        tsel[0] = term_sel(kind1_reg, node1_reg, FLD_N);
        tsel[1] = term_sel(kind1_reg, node1_reg, FLD_DR);
        tsel[2] = term_sel(kind1_reg, node1_reg, FLD_DS);
        tsel[3] = term_sel(KIND_Q8, adj_a(node1_reg), FLD_N);
        tsel[4] = term_sel(KIND_Q8, adj_b(node1_reg), FLD_N);
        tsel[5] = term_sel(KIND_Q8, adj_a(node1_reg), FLD_DR);
        tsel[6] = term_sel(KIND_Q8, adj_b(node1_reg), FLD_DR);
        tsel[7] = term_sel(KIND_Q8, adj_a(node1_reg), FLD_DS);
        tsel[8] = term_sel(KIND_Q8, adj_b(node1_reg), FLD_DS);

        for (int k = 0; k < SLOTS; k++) begin
            x2_next[k]   = pick(tsel[k].x, b1);
            y2_next[k]   = pick(tsel[k].y, b1);
            sh2_next[k]  = tsel[k].sh;
            neg2_next[k] = tsel[k].neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            last2_reg <= last1_reg;
            node2_reg <= node1_reg;
            corr2_reg <= (kind1_reg == KIND_Q8) && (node1_reg < NODE_W'(4));
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            sh2_reg   <= sh2_next;
            neg2_reg  <= neg2_next;
        end
    end

    // stage 3: multiply
    logic signed [2*OPW-1:0] m3 [SLOTS];
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            m3[k] = x2_reg[k] * y2_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            last3_reg <= last2_reg;
            node3_reg <= node2_reg;
            corr3_reg <= corr2_reg;
            sh3_reg   <= sh2_reg;
            neg3_reg  <= neg2_reg;
            for (int k = 0; k < SLOTS; k++) begin
                p3_reg[k] <= PW'(m3[k]);
            end
        end
    end

    // stage 4: round, corner correction, saturate
    logic signed [PW-1:0]    t4 [SLOTS];
    logic signed [PW-1:0]    nf, drf, dsf;
    logic signed [OUT_W-1:0] n4_next, dr4_next, ds4_next;
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            t4[k] = rnd_shift(p3_reg[k], sh_amt(sh3_reg[k]));
            if (neg3_reg[k]) begin
                t4[k] = -t4[k];
            end
        end
        nf  = t4[0];
        drf = t4[1];
        dsf = t4[2];
        if (corr3_reg) begin
            nf  = nf  - rnd_shift(t4[3] + t4[4], 1);
            drf = drf - rnd_shift(t4[5] + t4[6], 1);
            dsf = dsf - rnd_shift(t4[7] + t4[8], 1);
        end
        n4_next  = sat(nf);
        dr4_next = de_reg ? sat(drf) : '0;
        ds4_next = de_reg ? sat(dsf) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            last4_reg <= last3_reg;
            node4_reg <= node3_reg;
            n4_reg    <= n4_next;
            dr4_reg   <= dr4_next;
            ds4_reg   <= ds4_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tlast  = last4_reg;
    assign m_tdata  = {ds4_reg, dr4_reg, n4_reg, node4_reg};

`ifndef ASSERT_OFF
    a_slopes_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !de_reg) |-> (dr4_reg == '0 && ds4_reg == '0))
        else $error("slopes not zero while derivatives disabled");

    a_last_node: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
        (node4_reg == NODE_W'(3) || node4_reg == NODE_W'(7) || node4_reg == NODE_W'(8)))
        else $error("last flag on a node that cannot end an element");

    a_center_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && node4_reg == NODE_W'(8)) |-> m_tlast)
        else $error("center node without last flag");

    a_hold_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (kind0_reg != KIND_NONE))
        else $error("unknown kind entered the sequencer");
`endif

endmodule

// ===== tb/quad_shape_checker.sv =====
// ----------------------------------------------------------------------------
// quad_shape_checker: node result predictor and comparator
// Watches the input and result channels of the shape function unit, computes
// the expected node results of every accepted input transfer and compares each
// result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module quad_shape_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_nodes
);
    import qsfe_pkg::*;

    typedef struct packed {
        logic [3:0]  node;
        logic [19:0] shape;
        logic [19:0] dr;
        logic [19:0] ds;
        logic        last;
    } node_res_t;

    node_res_t node_queue[$];
    logic      deriv_en;

    function automatic longint round_sh(longint p, int sh);
        longint mag;
        mag = (p < 0) ? -p : p;
        mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic longint mul_rnd(longint a, longint b, int sh);
        return round_sh(a * b, sh);
    endfunction

    function automatic logic [19:0] clip20(longint v);
        if (v > 524287)
            v = 524287;
        if (v < -524288)
            v = -524288;
        return v[19:0];
    endfunction

    task automatic predict_nodes(logic [17:0] r_in, logic [17:0] s_in, kind_t kind);
        longint n[9], dr[9], ds[9];
        longint r, s, one, hf, rp, rm, sp, sm, r2, s2;
        longint rrp, rrm, ssp, ssm, rhp, rhm, shp, shm;
        int count, i, a, b;
        int adj_a_tab[4];
        int adj_b_tab[4];
        node_res_t e;
        adj_a_tab = '{4, 4, 5, 6};
        adj_b_tab = '{7, 5, 6, 7};
        r = longint'($signed(r_in));
        s = longint'($signed(s_in));
        one = 65536;
        hf = 32768;
        rp = one + r; rm = one - r; sp = one + s; sm = one - s;
        r2 = one - mul_rnd(r, r, 16);
        s2 = one - mul_rnd(s, s, 16);
        count = 0;
        if (kind == KIND_Q4 || kind == KIND_Q8) begin
            n[0] = mul_rnd(rp, sp, 18);
            n[1] = mul_rnd(rm, sp, 18);
            n[2] = mul_rnd(rm, sm, 18);
            n[3] = mul_rnd(rp, sm, 18);
            dr[0] = round_sh(sp, 2); dr[1] = -dr[0];
            dr[3] = round_sh(sm, 2); dr[2] = -dr[3];
            ds[0] = round_sh(rp, 2); ds[3] = -ds[0];
            ds[1] = round_sh(rm, 2); ds[2] = -ds[1];
            count = 4;
            if (kind == KIND_Q8) begin
                n[4] = mul_rnd(r2, sp, 17);
                n[5] = mul_rnd(rm, s2, 17);
                n[6] = mul_rnd(r2, sm, 17);
                n[7] = mul_rnd(rp, s2, 17);
                dr[4] = -mul_rnd(r, sp, 16);
                dr[5] = -round_sh(s2, 1);
                dr[6] = -mul_rnd(r, sm, 16);
                dr[7] = round_sh(s2, 1);
                ds[4] = round_sh(r2, 1);
                ds[5] = -mul_rnd(rm, s, 16);
                ds[6] = -round_sh(r2, 1);
                ds[7] = -mul_rnd(rp, s, 16);
                // corner minus half of its two midside neighbors
                for (i = 0; i < 4; i++) begin
                    a = adj_a_tab[i];
                    b = adj_b_tab[i];
                    n[i] -= round_sh(n[a] + n[b], 1);
                    dr[i] -= round_sh(dr[a] + dr[b], 1);
                    ds[i] -= round_sh(ds[a] + ds[b], 1);
                end
                count = 8;
            end
        end else if (kind == KIND_Q9) begin
            rrp = mul_rnd(r, rp, 16); rrm = mul_rnd(r, rm, 16);
            ssp = mul_rnd(s, sp, 16); ssm = mul_rnd(s, sm, 16);
            rhp = r + hf; rhm = r - hf; shp = s + hf; shm = s - hf;
            n[0] = mul_rnd(rrp, ssp, 18);
            n[1] = -mul_rnd(rrm, ssp, 18);
            n[2] = mul_rnd(rrm, ssm, 18);
            n[3] = -mul_rnd(rrp, ssm, 18);
            n[4] = mul_rnd(ssp, r2, 17);
            n[5] = -mul_rnd(rrm, s2, 17);
            n[6] = -mul_rnd(ssm, r2, 17);
            n[7] = mul_rnd(rrp, s2, 17);
            n[8] = mul_rnd(r2, s2, 16);
            dr[0] = mul_rnd(rhp, ssp, 17);
            dr[1] = mul_rnd(rhm, ssp, 17);
            dr[2] = -mul_rnd(rhm, ssm, 17);
            dr[3] = -mul_rnd(rhp, ssm, 17);
            dr[4] = -mul_rnd(r, ssp, 16);
            dr[5] = mul_rnd(rhm, s2, 16);
            dr[6] = mul_rnd(r, ssm, 16);
            dr[7] = mul_rnd(rhp, s2, 16);
            dr[8] = -mul_rnd(r, s2, 15);
            ds[0] = mul_rnd(shp, rrp, 17);
            ds[1] = -mul_rnd(shp, rrm, 17);
            ds[2] = -mul_rnd(shm, rrm, 17);
            ds[3] = mul_rnd(shm, rrp, 17);
            ds[4] = mul_rnd(shp, r2, 16);
            ds[5] = mul_rnd(s, rrm, 16);
            ds[6] = mul_rnd(shm, r2, 16);
            ds[7] = -mul_rnd(s, rrp, 16);
            ds[8] = -mul_rnd(s, r2, 15);
            count = 9;
        end
        for (i = 0; i < count; i++) begin
            e.node  = i[3:0];
            e.shape = clip20(n[i]);
            e.dr    = deriv_en ? clip20(dr[i]) : 20'd0;
            e.ds    = deriv_en ? clip20(ds[i]) : 20'd0;
            e.last  = (i == count - 1);
            node_queue.push_back(e);
        end
    endtask

    always @(posedge aclk) begin
        node_res_t e;
        if (!aresetn) begin
            deriv_en <= 1'b1;
            node_queue.delete();
            pending_nodes = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (node_queue.size() == 0) begin
                    $error("unexpected node result transfer %h", m_tdata);
                    fail_count++;
                end else begin
                    e = node_queue.pop_front();
                    if (m_tdata[3:0] !== e.node) begin
                        $error("node_number expected %0d actual %0d", e.node, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[23:4] !== e.shape) begin
                        $error("shape_value expected %h actual %h", e.shape, m_tdata[23:4]);
                        fail_count++;
                    end
                    if (m_tdata[43:24] !== e.dr) begin
                        $error("slope_r expected %h actual %h", e.dr, m_tdata[43:24]);
                        fail_count++;
                    end
                    if (m_tdata[63:44] !== e.ds) begin
                        $error("slope_s expected %h actual %h", e.ds, m_tdata[63:44]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_node expected %0d actual %0d", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            // prediction uses the setting in force before this edge's write
            if (s_tvalid && s_tready)
                predict_nodes(s_tdata[17:0], s_tdata[35:18], kind_t'(s_tuser));
            if (cfg_wr_en)
                deriv_en <= cfg_wr_data;
            pending_nodes = node_queue.size();
        end
    end
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: shape function unit testbench
// Drives directed and random coordinate pairs of every element kind under
// both derivative settings with random idling and a long result hold-off.
// ----------------------------------------------------------------------------
module tb;
    import qsfe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_nodes;
    int          cycle_count;
    logic        quiet_phase;
    logic        hold_off_req;

    quad_shape_function_eval uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    quad_shape_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_nodes(pending_nodes)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL quad_shape_function_eval");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                for (n = 0; n < 200; n++)
                    @(negedge aclk);
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // leaves the item offered; the caller drops s_tvalid when the batch ends
    task automatic send_item(logic [17:0] r, logic [17:0] s, logic [1:0] kind);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, s, r};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [17:0] rand_coord();
        logic [17:0] v;
        case ($urandom_range(0, 9))
            0: v = 18'($urandom);
            1: v = 18'sd65536;
            2: v = -18'sd65536;
            default: v = 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
        return v;
    endfunction

    function automatic logic [1:0] rand_kind();
        return ($urandom_range(0, 19) == 0) ? 2'(KIND_NONE) : 2'($urandom_range(0, 2));
    endfunction

    task automatic drain_and_config(logic value);
        s_tvalid <= 1'b0;
        while (pending_nodes != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int i, k;
        logic [17:0] edge_vals[7];
        edge_vals = '{18'sd65536, -18'sd65536, 18'sd0, 18'sd32768, -18'sd32768,
                      18'h1FFFF, 18'h20000};
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        quiet_phase = 1'b0; hold_off_req = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        // directed: extremes, every kind, out-of-range and unknown kind
        for (k = 0; k < 4; k++)
            for (i = 0; i < 5; i++)
                send_item(edge_vals[i], edge_vals[(i + k + 1) % 7], 2'(k));
        send_item(18'h1FFFF, 18'h20000, 2'(KIND_Q9));
        send_item(18'h20000, 18'h1FFFF, 2'(KIND_Q8));
        send_item(18'h3FFFF, 18'h2AAAA, 2'(KIND_Q4));
        drain_and_config(1'b0);
        for (i = 0; i < 25; i++)
            send_item(rand_coord(), rand_coord(), rand_kind());
        drain_and_config(1'b1);
        // hold off the receiver while items keep coming; hold the request
        // longer than any stall burst so the receiver sees it
        @(negedge aclk);
        hold_off_req <= 1'b1;
        repeat (16) @(negedge aclk);
        hold_off_req <= 1'b0;
        for (i = 0; i < 30; i++)
            send_item(rand_coord(), rand_coord(), rand_kind());
        drain_and_config(1'b0);
        for (i = 0; i < 10; i++)
            send_item(rand_coord(), rand_coord(), rand_kind());
        drain_and_config(1'b1);
        quiet_phase <= 1'b1;
        for (i = 0; i < 20; i++)
            send_item(rand_coord(), rand_coord(), rand_kind());
        s_tvalid <= 1'b0;
        while (pending_nodes != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS quad_shape_function_eval");
        else
            $display("FAIL quad_shape_function_eval");
        $finish;
    end
endmodule
